### rtl/core/aedl_pkg.sv
// aedl_pkg: shared types and constants of the echo delay line
`default_nettype none

package aedl_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 27;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_TARGET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WET_MIX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TONE_ALPHA = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BYPASS = 3'd5;

  // reset values
  localparam logic [26:0] RESET_DELAY = 27'd614400;
  localparam logic [15:0] RESET_FEEDBACK = 16'd32768;
  localparam logic [16:0] RESET_WET = 17'd32768;
  localparam logic [16:0] RESET_GAIN = 17'd32768;
  localparam logic [15:0] RESET_ALPHA = 16'd42743;

  localparam logic [13:0] HOLD_SAMPLES = 14'd10000;
  localparam logic [6:0] FADE_FULL = 7'd100;
  localparam logic [26:0] MOVE_THRESHOLD = 27'd26;
  localparam logic [16:0] UNITY = 17'd65536;

  // floor(p / 100) = (p * FADE_RECIP) >> FADE_SHIFT for p below 2^23
  localparam logic [23:0] FADE_RECIP = 24'd10737419;
  localparam int unsigned FADE_SHIFT = 30;
  localparam logic [24:0] FADE_BIAS = 25'd3276800;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CTRL,
    S_MOD,
    S_POS,
    S_RD0,
    S_RD1,
    S_INTP,
    S_FADE1,
    S_FADE2,
    S_TONE1,
    S_TONE2,
    S_FB,
    S_MIX,
    S_SCALE,
    S_OUT
  } state_e;

endpackage

`default_nettype wire

### rtl/core/aedl_stream_if.sv
// aedl_stream_if: valid/ready sample channels into and out of the echo delay line
`default_nettype none

interface aedl_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface aedl_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

### rtl/core/audio_echo_delay_line_unit.sv
// audio_echo_delay_line_unit: echo delay line with fade, lowpass tone, feedback and mix
// one sample in flight: the next sample is accepted only once the current one has gone
// through the modulo steps (M = 28 - clog2(DEPTH*256), 2 steps at the default depth) and
// into the result register; in bypass a sample goes straight to the result register
// the delay memory is one single-port ram, read twice and written once per non-bypassed sample
// reset clears pointer, fill flag and control state; unwritten ram entries read as zero
`default_nettype none

module audio_echo_delay_line_unit
  import aedl_pkg::*;
#(
  parameter int unsigned DEPTH = 262144
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  aedl_in_if.sink                    in_i,
  aedl_out_if.source                 out_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned WW = 30;
  localparam longint TOTAL = longint'(DEPTH) * 256;
  localparam logic [WW-1:0] TOTAL_W = WW'(TOTAL);
  localparam int MOD_STEPS = (28 - $clog2(TOTAL)) > 0 ? (28 - $clog2(TOTAL)) : 0;
  localparam logic [2:0] K_START = 3'((MOD_STEPS > 0) ? MOD_STEPS - 1 : 0);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  // configuration
  logic [26:0] dtgt_q;
  logic [15:0] fbg_q;
  logic [16:0] wet_q;
  logic [16:0] gain_q;
  logic [15:0] alpha_q;
  logic        bypass_q;

  // control state
  state_e      state_q, state_d;
  logic [AW-1:0] wp_q;
  logic        wrapped_q;
  logic [26:0] cd_q;
  logic [26:0] last_q;
  logic [13:0] hold_q;
  logic [6:0]  fade_q;
  logic signed [15:0] tprev_q;
  logic [2:0]  k_q;
  logic        out_valid_q;

  // datapath registers
  logic signed [15:0] x_q;
  logic [WW-1:0]      v_q;
  logic [AW-1:0]      r0_q, r1_q;
  logic [7:0]         f_q;
  logic               v0_q, v1_q;
  logic signed [15:0] m0_q;
  logic signed [15:0] rd_q;
  logic [22:0]        p_q;
  logic signed [15:0] faded_q;
  logic signed [33:0] t1_q;
  logic signed [15:0] tone_q;
  logic signed [33:0] dry_q;
  logic signed [34:0] mix_q;
  logic signed [15:0] y_q;
  logic signed [15:0] out_data_q;

  // memory
  logic [15:0]   mem_q [DEPTH];
  logic [15:0]   rdata_q;
  logic          mem_re, mem_we;
  logic [AW-1:0] raddr;
  logic          in_ready;

  // ---------------- state machine ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_i.valid) state_d = bypass_q ? S_OUT : S_CTRL;
      S_CTRL:  state_d = (MOD_STEPS == 0) ? S_POS : S_MOD;
      S_MOD:   if (k_q == '0) state_d = S_POS;
      S_POS:   state_d = S_RD0;
      S_RD0:   state_d = S_RD1;
      S_RD1:   state_d = S_INTP;
      S_INTP:  state_d = S_FADE1;
      S_FADE1: state_d = S_FADE2;
      S_FADE2: state_d = S_TONE1;
      S_TONE1: state_d = S_TONE2;
      S_TONE2: state_d = S_FB;
      S_FB:    state_d = S_MIX;
      S_MIX:   state_d = S_SCALE;
      S_SCALE: state_d = S_OUT;
      S_OUT:   if (!out_valid_q || out_o.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    mem_re   = 1'b0;
    mem_we   = 1'b0;
    raddr    = r0_q;
    unique case (state_q)
      S_IDLE: in_ready = 1'b1;
      S_RD0: begin
        mem_re = 1'b1;
        raddr  = r0_q;
      end
      S_RD1: begin
        mem_re = 1'b1;
        raddr  = r1_q;
      end
      S_FB: mem_we = 1'b1;
      default: ;
    endcase
  end

  assign in_i.ready       = in_ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_data_q;

  wire in_xfer = in_i.valid && in_ready;

  // ---------------- fade control ----------------
  logic [26:0] tgt_diff;
  logic        moved;
  logic [13:0] hold_eff, hold_n;
  logic [6:0]  fade_n;
  logic [26:0] cd_n;

  assign tgt_diff = (dtgt_q >= last_q) ? dtgt_q - last_q : last_q - dtgt_q;
  assign moved    = tgt_diff >= MOVE_THRESHOLD;
  assign hold_eff = moved ? HOLD_SAMPLES : hold_q;

  always_comb begin
    hold_n = hold_eff;
    fade_n = fade_q;
    cd_n   = cd_q;
    if (hold_eff != '0) begin
      hold_n = hold_eff - 14'd1;
      if (fade_q != '0) fade_n = fade_q - 7'd1;
      // silent: jump to the new target
      if (fade_n == '0) cd_n = dtgt_q;
    end else if (fade_q < FADE_FULL) begin
      fade_n = fade_q + 7'd1;
    end
  end

  // ---------------- read position ----------------
  logic [WW-1:0] mod_cmp;
  logic [WW-1:0] pos_sum, pos;
  logic [AW-1:0] r0_n;

  assign mod_cmp = TOTAL_W << k_q;
  assign pos_sum = WW'({wp_q, 8'h00}) + (TOTAL_W - v_q);
  assign pos     = (pos_sum >= TOTAL_W) ? pos_sum - TOTAL_W : pos_sum;
  assign r0_n    = pos[AW+7:8];

  // ---------------- arithmetic ----------------
  logic signed [15:0] m0_n, m1_n;
  logic signed [16:0] dm;
  logic signed [25:0] iprod;
  logic signed [26:0] iacc;
  logic signed [24:0] fprod, fsum;
  logic [46:0]        qprod;
  logic [15:0]        q16;
  logic [16:0]        one_minus_a;
  logic signed [33:0] t1_n, aprev;
  logic signed [34:0] tsum;
  logic signed [18:0] tone_raw;
  logic signed [15:0] tone_n;
  logic signed [33:0] fbp, fbs;
  logic signed [17:0] fb;
  logic signed [18:0] wsum;
  logic [15:0]        wval;
  logic [16:0]        wet_eff, dry_share, gain_eff;
  logic signed [33:0] dry_n, wetp;
  logic signed [34:0] mix_n;
  logic signed [52:0] sprod, ssum;
  logic signed [21:0] y_raw;
  logic signed [15:0] y_n;

  assign m0_n  = v0_q ? $signed(rdata_q) : 16'sd0;
  assign m1_n  = v1_q ? $signed(rdata_q) : 16'sd0;
  // m0*(256-f) + m1*f = m0*256 + (m1-m0)*f
  assign dm    = 17'(m1_n) - 17'(m0_q);
  assign iprod = dm * $signed({1'b0, f_q});
  assign iacc  = (27'(m0_q) <<< 8) + 27'(iprod) + 27'sd128;

  assign fprod = rd_q * $signed({1'b0, fade_q});
  assign fsum  = fprod + $signed(FADE_BIAS);
  assign qprod = p_q * FADE_RECIP;
  // quotient minus 32768 recenters the biased value
  assign q16   = qprod[FADE_SHIFT+15:FADE_SHIFT] - 16'd32768;

  assign one_minus_a = UNITY - {1'b0, alpha_q};
  assign t1_n  = $signed({1'b0, one_minus_a}) * faded_q;
  assign aprev = $signed({1'b0, alpha_q}) * tprev_q;
  assign tsum  = 35'(t1_q) + 35'(aprev) + 35'sd32768;
  assign tone_raw = tsum[34:16];
  assign tone_n = (tone_raw > 19'sd32767) ? 16'sd32767 :
                  (tone_raw < -19'sd32768) ? -16'sd32768 : tone_raw[15:0];

  assign fbp  = $signed({1'b0, fbg_q}) * tone_q;
  assign fbs  = fbp + 34'sd32768;
  assign fb   = fbs[33:16];
  assign wsum = 19'(fb) + 19'(x_q);
  assign wval = (wsum > 19'sd32767) ? 16'h7FFF :
                (wsum < -19'sd32768) ? 16'h8000 : wsum[15:0];

  assign wet_eff   = (wet_q > UNITY) ? UNITY : wet_q;
  assign gain_eff  = (gain_q > UNITY) ? UNITY : gain_q;
  assign dry_share = UNITY - wet_eff;
  assign dry_n = $signed({1'b0, dry_share}) * x_q;
  assign wetp  = $signed({1'b0, wet_eff}) * tone_q;
  assign mix_n = 35'(dry_q) + 35'(wetp);

  assign sprod = mix_q * $signed({1'b0, gain_eff});
  assign ssum  = sprod + 53'sd1073741824;
  assign y_raw = ssum[52:31];
  assign y_n   = (y_raw > 22'sd32767) ? 16'sd32767 :
                 (y_raw < -22'sd32767) ? -16'sd32767 : y_raw[15:0];

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dtgt_q      <= RESET_DELAY;
      fbg_q       <= RESET_FEEDBACK;
      wet_q       <= RESET_WET;
      gain_q      <= RESET_GAIN;
      alpha_q     <= RESET_ALPHA;
      bypass_q    <= 1'b0;
      wp_q        <= '0;
      wrapped_q   <= 1'b0;
      cd_q        <= RESET_DELAY;
      last_q      <= RESET_DELAY;
      hold_q      <= '0;
      fade_q      <= FADE_FULL;
      tprev_q     <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_DELAY_TARGET:  dtgt_q   <= cfg_data_i[26:0];
          CFG_FEEDBACK_GAIN: fbg_q    <= cfg_data_i[15:0];
          CFG_WET_MIX:       wet_q    <= cfg_data_i[16:0];
          CFG_OUTPUT_GAIN:   gain_q   <= cfg_data_i[16:0];
          CFG_TONE_ALPHA:    alpha_q  <= cfg_data_i[15:0];
          CFG_BYPASS:        bypass_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (state_q == S_CTRL) begin
        hold_q <= hold_n;
        fade_q <= fade_n;
        cd_q   <= cd_n;
        if (moved) last_q <= dtgt_q;
        k_q    <= K_START;
      end
      if (state_q == S_MOD) k_q <= k_q - 3'd1;
      if (state_q == S_TONE2) tprev_q <= tone_n;
      if (state_q == S_FB) begin
        wp_q <= (wp_q == LAST_ADDR) ? '0 : wp_q + AW'(1);
        if (wp_q == LAST_ADDR) wrapped_q <= 1'b1;
      end
      if (state_q == S_OUT && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      x_q <= in_i.sample_in;
      y_q <= in_i.sample_in;
    end
    unique case (state_q)
      S_CTRL: begin
        v_q   <= WW'(cd_n);
        dry_q <= dry_n;
      end
      S_MOD: if (v_q >= mod_cmp) v_q <= v_q - mod_cmp;
      S_POS: begin
        r0_q <= r0_n;
        r1_q <= (r0_n == LAST_ADDR) ? '0 : r0_n + AW'(1);
        f_q  <= pos[7:0];
        v0_q <= wrapped_q || (r0_n < wp_q);
        v1_q <= wrapped_q || (((r0_n == LAST_ADDR) ? '0 : r0_n + AW'(1)) < wp_q);
      end
      S_RD1:   m0_q    <= m0_n;
      S_INTP:  rd_q    <= iacc[23:8];
      S_FADE1: p_q     <= fsum[22:0];
      S_FADE2: faded_q <= $signed(q16);
      S_TONE1: t1_q    <= t1_n;
      S_TONE2: tone_q  <= tone_n;
      S_MIX:   mix_q   <= mix_n;
      S_SCALE: y_q     <= y_n;
      S_OUT:   if (!out_valid_q || out_o.ready) out_data_q <= y_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[wp_q] <= wval;
    if (mem_re) rdata_q <= mem_q[raddr];
  end

`ifndef SYNTHESIS
  a_fade_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fade_q <= FADE_FULL)
    else $error("fade level above full scale");

  a_hold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_q <= HOLD_SAMPLES)
    else $error("hold counter above hold length");

  a_jump_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cd_q != $past(cd_q)) |-> (fade_q == '0))
    else $error("read delay moved while the echo was audible");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q <= LAST_ADDR)
    else $error("write pointer beyond memory depth");

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> !mem_we)
    else $error("two memory writes for one transaction");
`endif

endmodule

`default_nettype wire
